FILE: rtl/core/bci_pkg.sv
// Shared types, constants and helpers of the binomial confidence interval block.
`default_nettype none
package bci_pkg;

  localparam int unsigned CNT_W = 10;
  localparam int unsigned DBL_W = 64;
  localparam int unsigned K_W   = CNT_W + 1;

  localparam logic [K_W-1:0]   MAX_TRIALS  = 11'd1023;
  localparam logic [DBL_W-1:0] DBL_ZERO    = 64'h0000_0000_0000_0000;
  localparam logic [DBL_W-1:0] DBL_ONE     = 64'h3FF0_0000_0000_0000;
  localparam logic [DBL_W-1:0] DBL_TWO     = 64'h4000_0000_0000_0000;
  localparam logic [DBL_W-1:0] DBL_HUNDRED = 64'h4059_0000_0000_0000;
  localparam logic [DBL_W-1:0] DBL_RESCALE = 64'h4629_3E59_39A0_8CEA;
  localparam logic [DBL_W-1:0] DBL_WIDTH   = 64'h3EE4_F8B5_88E3_68F1;
  localparam logic [DBL_W-1:0] DBL_QNAN    = 64'hFFF8_0000_0000_0000;

  typedef enum logic [2:0] {
    FOP_ADD,
    FOP_SUB,
    FOP_MUL,
    FOP_DIV,
    FOP_GT
  } fop_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PREN,
    F_ADD,
    F_MUL,
    F_DIV,
    F_NORM,
    F_ROUND,
    F_DONE
  } fpu_state_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RATIO,
    S_LV,
    S_LTGT,
    S_UV1,
    S_UV2,
    S_UTGT,
    S_WID,
    S_CMPW,
    S_ONEM,
    S_ODDS,
    S_TTOT,
    S_TPART,
    S_TCHK,
    S_RS1,
    S_RS2,
    S_RS3,
    S_TINC,
    S_TM1,
    S_TM2,
    S_TDIV,
    S_TFIN,
    S_DEC,
    S_SUM,
    S_HALF,
    S_OUT
  } bci_state_e;

  typedef struct packed {
    logic             start;
    fop_e             op;
    logic [DBL_W-1:0] a;
    logic [DBL_W-1:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic             done;
    logic [DBL_W-1:0] res;
  } fpu_rsp_t;

  // Exact conversion of a small count to a double.
  function automatic logic [DBL_W-1:0] int_to_dbl(input logic [K_W-1:0] v);
    logic [3:0]  msb;
    logic [52:0] m53;
    logic [DBL_W-1:0] r;
    msb = 4'd0;
    for (int i = 0; i < K_W; i++) begin
      if (v[i]) begin
        msb = 4'(i);
      end
    end
    m53 = {42'd0, v} << (6'd52 - {2'b00, msb});
    if (v == '0) begin
      r = DBL_ZERO;
    end else begin
      r = {1'b0, 11'(11'd1023 + {7'd0, msb}), m53[51:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bci_if.sv
// Valid/ready channel interfaces for the request and result words.
`default_nettype none
interface bci_in_if import bci_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] successes;
  logic [CNT_W-1:0] trials;
  modport source (output valid, successes, trials, input ready);
  modport sink (input valid, successes, trials, output ready);
endinterface

interface bci_out_if import bci_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DBL_W-1:0] lower_limit;
  logic [DBL_W-1:0] upper_limit;
  logic [DBL_W-1:0] ratio;
  logic             status;
  modport source (output valid, lower_limit, upper_limit, ratio, status, input ready);
  modport sink (input valid, lower_limit, upper_limit, ratio, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bci_fpu.sv
// Multi-cycle IEEE double unit: add, subtract, multiply, divide and compare.
`default_nettype none
module bci_fpu import bci_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fpu_req_t req_i,
  output fpu_rsp_t rsp_o
);

  fpu_state_e state_q, state_d;

  logic               sr_q, sr_d;
  logic               eff_sub_q, eff_sub_d;
  logic               is_div_q, is_div_d;
  logic signed [12:0] ea_q, ea_d, eb_q, eb_d, e_q, e_d;
  logic [52:0]        ma_q, ma_d, mb_q, mb_d;
  logic [105:0]       acc_q, acc_d, mx_q, mx_d;
  logic [53:0]        rem_q, rem_d;
  logic [64:0]        quo_q, quo_d;
  logic [6:0]         cnt_q, cnt_d;
  logic [63:0]        m_q, m_d;
  logic               st_q, st_d;
  logic [63:0]        res_q, res_d;

  logic [63:0]  a, b, b_eff, big, sml, ka, kb, sp_res;
  logic         a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sp, gt, sx, swap;
  logic signed [12:0] d13, shamt, e2, e3;
  logic [63:0]  x64, y64, ysh, m2;
  logic         yst, st2, ge, up;
  logic [64:0]  sum65, quo_n;
  logic [105:0] acc_n;
  logic [53:0]  rem_n, q54;
  logic [52:0]  q, q53;

  assign a = req_i.a;
  assign b = req_i.b;
  assign b_eff = (req_i.op == FOP_SUB) ? {~b[63], b[62:0]} : b;
  assign a_nan = (&a[62:52]) & (|a[51:0]);
  assign b_nan = (&b[62:52]) & (|b[51:0]);
  assign a_inf = (&a[62:52]) & ~(|a[51:0]);
  assign b_inf = (&b[62:52]) & ~(|b[51:0]);
  assign a_zero = ~(|a[62:0]);
  assign b_zero = ~(|b[62:0]);
  assign sx = a[63] ^ b[63];
  assign ka = a[63] ? ~a : {1'b1, a[62:0]};
  assign kb = b[63] ? ~b : {1'b1, b[62:0]};
  assign gt = ~a_nan & ~b_nan & ~(a_zero & b_zero) & (ka > kb);
  assign swap = (req_i.op == FOP_ADD || req_i.op == FOP_SUB) && (b_eff[62:0] > a[62:0]);
  assign big = swap ? b_eff : a;
  assign sml = swap ? a : ((req_i.op == FOP_ADD || req_i.op == FOP_SUB) ? b_eff : b);

  always_comb begin
    sp = 1'b0;
    sp_res = DBL_ZERO;
    if (req_i.op == FOP_GT) begin
      sp = 1'b1;
      sp_res = {63'd0, gt};
    end else if (a_nan) begin
      sp = 1'b1;
      sp_res = a | 64'h0008_0000_0000_0000;
    end else if (b_nan) begin
      sp = 1'b1;
      sp_res = b | 64'h0008_0000_0000_0000;
    end else begin
      unique case (req_i.op)
        FOP_ADD, FOP_SUB: begin
          sp = a_inf | b_inf | a_zero | b_zero;
          if (a_inf && b_inf && (a[63] != b_eff[63])) begin
            sp_res = DBL_QNAN;
          end else if (a_inf) begin
            sp_res = a;
          end else if (b_inf) begin
            sp_res = b_eff;
          end else if (a_zero && b_zero) begin
            sp_res = {a[63] & b_eff[63], 63'd0};
          end else if (a_zero) begin
            sp_res = b_eff;
          end else begin
            sp_res = a;
          end
        end
        FOP_MUL: begin
          sp = a_inf | b_inf | a_zero | b_zero;
          if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            sp_res = DBL_QNAN;
          end else if (a_inf || b_inf) begin
            sp_res = {sx, 11'h7FF, 52'd0};
          end else begin
            sp_res = {sx, 63'd0};
          end
        end
        FOP_DIV: begin
          sp = a_inf | b_inf | a_zero | b_zero;
          if ((a_inf && b_inf) || (a_zero && b_zero)) begin
            sp_res = DBL_QNAN;
          end else if (a_inf || b_zero) begin
            sp_res = {sx, 11'h7FF, 52'd0};
          end else begin
            sp_res = {sx, 63'd0};
          end
        end
        default: begin
          sp = 1'b1;
          sp_res = DBL_QNAN;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    sr_d = sr_q;
    eff_sub_d = eff_sub_q;
    is_div_d = is_div_q;
    ea_d = ea_q;
    eb_d = eb_q;
    e_d = e_q;
    ma_d = ma_q;
    mb_d = mb_q;
    acc_d = acc_q;
    mx_d = mx_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    m_d = m_q;
    st_d = st_q;
    res_d = res_q;

    d13 = ea_q - eb_q;
    x64 = {1'b0, ma_q, 10'd0};
    y64 = {1'b0, mb_q, 10'd0};
    if (d13 > 13'sd63) begin
      ysh = '0;
      yst = |mb_q;
    end else begin
      ysh = y64 >> d13[5:0];
      yst = |(y64 << (7'd64 - {1'b0, d13[5:0]}));
    end
    sum65 = eff_sub_q ? ({x64, 1'b0} - {ysh, yst}) : ({x64, 1'b0} + {ysh, yst});

    acc_n = mb_q[0] ? (acc_q + mx_q) : acc_q;

    ge = rem_q >= {1'b0, mb_q};
    rem_n = ge ? (rem_q - {1'b0, mb_q}) : rem_q;
    quo_n = {quo_q[63:0], ge};

    shamt = 13'sd1 - e_q;
    if (e_q < 13'sd1) begin
      e2 = 13'sd1;
      if (shamt > 13'sd64) begin
        m2 = '0;
        st2 = st_q | (|m_q);
      end else begin
        m2 = m_q >> shamt[6:0];
        st2 = st_q | (|(m_q << (7'd64 - shamt[6:0])));
      end
    end else begin
      e2 = e_q;
      m2 = m_q;
      st2 = st_q;
    end
    q = m2[63:11];
    up = m2[10] & ((|m2[9:0]) | st2 | q[0]);
    q54 = {1'b0, q} + {53'd0, up};
    if (q54[53]) begin
      q53 = q54[53:1];
      e3 = e2 + 13'sd1;
    end else begin
      q53 = q54[52:0];
      e3 = e2;
    end

    unique case (state_q)
      F_IDLE: begin
        if (req_i.start) begin
          if (sp) begin
            res_d = sp_res;
            state_d = F_DONE;
          end else begin
            ea_d = (big[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, big[62:52]});
            eb_d = (sml[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, sml[62:52]});
            ma_d = {|big[62:52], big[51:0]};
            mb_d = {|sml[62:52], sml[51:0]};
            eff_sub_d = big[63] ^ sml[63];
            is_div_d = (req_i.op == FOP_DIV);
            if (req_i.op == FOP_ADD || req_i.op == FOP_SUB) begin
              sr_d = big[63];
              state_d = F_ADD;
            end else begin
              sr_d = sx;
              state_d = F_PREN;
            end
          end
        end
      end
      F_ADD: begin
        if (sum65 == '0) begin
          res_d = DBL_ZERO;
          state_d = F_DONE;
        end else begin
          m_d = sum65[64:1];
          st_d = sum65[0];
          e_d = ea_q + 13'sd1;
          state_d = F_NORM;
        end
      end
      F_PREN: begin
        if (ma_q[52] && mb_q[52]) begin
          acc_d = '0;
          mx_d = {53'd0, ma_q};
          rem_d = {1'b0, ma_q};
          quo_d = '0;
          cnt_d = '0;
          state_d = is_div_q ? F_DIV : F_MUL;
        end else begin
          if (!ma_q[52]) begin
            ma_d = ma_q << 1;
            ea_d = ea_q - 13'sd1;
          end
          if (!mb_q[52]) begin
            mb_d = mb_q << 1;
            eb_d = eb_q - 13'sd1;
          end
        end
      end
      F_MUL: begin
        acc_d = acc_n;
        mx_d = mx_q << 1;
        mb_d = mb_q >> 1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd52) begin
          m_d = acc_n[105:42];
          st_d = |acc_n[41:0];
          e_d = ea_q + eb_q - 13'sd1022;
          state_d = F_NORM;
        end
      end
      F_DIV: begin
        rem_d = {rem_n[52:0], 1'b0};
        quo_d = quo_n;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd64) begin
          m_d = quo_n[64:1];
          st_d = quo_n[0] | (rem_n != '0);
          e_d = ea_q - eb_q + 13'sd1023;
          state_d = F_NORM;
        end
      end
      F_NORM: begin
        if (m_q[63]) begin
          state_d = F_ROUND;
        end else begin
          m_d = m_q << 1;
          e_d = e_q - 13'sd1;
        end
      end
      F_ROUND: begin
        if (e3 > 13'sd2046) begin
          res_d = {sr_q, 11'h7FF, 52'd0};
        end else begin
          res_d = {sr_q, (q53[52] ? e3[10:0] : 11'd0), q53[51:0]};
        end
        state_d = F_DONE;
      end
      F_DONE: begin
        state_d = F_IDLE;
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q      <= sr_d;
    eff_sub_q <= eff_sub_d;
    is_div_q  <= is_div_d;
    ea_q      <= ea_d;
    eb_q      <= eb_d;
    e_q       <= e_d;
    ma_q      <= ma_d;
    mb_q      <= mb_d;
    acc_q     <= acc_d;
    mx_q      <= mx_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
    m_q       <= m_d;
    st_q      <= st_d;
    res_q     <= res_d;
  end

  assign rsp_o.done = (state_q == F_DONE);
  assign rsp_o.res  = res_q;

endmodule
`default_nettype wire

FILE: rtl/core/binomial_confidence_interval.sv
// Clopper-Pearson interval top level: sequencer, registers and result stage.
// One word at a time; an invalid request yields its result word the cycle after acceptance.
// A valid word needs about 34 bisection steps for the two limits together, each summing
// trials + 1 terms on the shared FPU, whose operations take longer for subnormal operands.
// Reset is asynchronous, active low; both tail registers reset to 1.0 and there is no
// clearing pass.
`default_nettype none
module binomial_confidence_interval import bci_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  bci_in_if.sink           in_i,
  bci_out_if.source        out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [DBL_W-1:0] pwdata,
  output logic [DBL_W-1:0] prdata,
  output logic             pready
);

  bci_state_e state_q, state_d;
  logic issued_q, issued_d;
  logic status_q, status_d;
  logic phase_q, phase_d;
  logic dir_q, dir_d;
  logic [CNT_W-1:0] x_q, x_d, n_q, n_d;
  logic [K_W-1:0] k_q, k_d;
  logic [DBL_W-1:0] low_pct_q, up_pct_q;
  logic [DBL_W-1:0] ratio_q, ratio_d, v_q, v_d, below_q, below_d, above_q, above_d;
  logic [DBL_W-1:0] target_q, target_d, odds_q, odds_d, term_q, term_d;
  logic [DBL_W-1:0] part_q, part_d, total_q, total_d, tmp_q, tmp_d;
  logic [DBL_W-1:0] lo_q, lo_d, up_q, up_d;
  logic [K_W-1:0] k_inc, n_ext, x_ext;
  logic in_range;

  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;

  bci_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .rsp_o  (fpu_rsp)
  );

  assign pready = 1'b1;
  assign prdata = paddr[3] ? up_pct_q : low_pct_q;

  assign k_inc = k_q + 11'd1;
  assign n_ext = {1'b0, n_q};
  assign x_ext = {1'b0, x_q};
  assign in_range = phase_q ? (k_q <= x_ext) : (k_q >= x_ext);

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.lower_limit = lo_q;
  assign out_o.upper_limit = up_q;
  assign out_o.ratio       = ratio_q;
  assign out_o.status      = status_q;

  always_comb begin
    state_d = state_q;
    status_d = status_q;
    phase_d = phase_q;
    dir_d = dir_q;
    x_d = x_q;
    n_d = n_q;
    k_d = k_q;
    ratio_d = ratio_q;
    v_d = v_q;
    below_d = below_q;
    above_d = above_q;
    target_d = target_q;
    odds_d = odds_q;
    term_d = term_q;
    part_d = part_q;
    total_d = total_q;
    tmp_d = tmp_q;
    lo_d = lo_q;
    up_d = up_q;
    fpu_req.start = 1'b0;
    fpu_req.op = FOP_ADD;
    fpu_req.a = DBL_ZERO;
    fpu_req.b = DBL_ZERO;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          x_d = in_i.successes;
          n_d = in_i.trials;
          if (in_i.trials == '0 || in_i.successes > in_i.trials
              || {1'b0, in_i.trials} > MAX_TRIALS) begin
            lo_d = DBL_ZERO;
            up_d = DBL_ZERO;
            ratio_d = DBL_ZERO;
            status_d = 1'b1;
            state_d = S_OUT;
          end else begin
            status_d = 1'b0;
            state_d = S_RATIO;
          end
        end
      end
      S_RATIO: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_DIV;
        fpu_req.a = int_to_dbl(x_ext);
        fpu_req.b = int_to_dbl(n_ext);
        if (fpu_rsp.done) begin
          ratio_d = fpu_rsp.res;
          if (x_q == '0) begin
            lo_d = DBL_ZERO;
            state_d = S_UV1;
          end else begin
            state_d = S_LV;
          end
        end
      end
      S_LV: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_DIV;
        fpu_req.a = ratio_q;
        fpu_req.b = DBL_TWO;
        if (fpu_rsp.done) begin
          v_d = fpu_rsp.res;
          below_d = DBL_ZERO;
          above_d = ratio_q;
          state_d = S_LTGT;
        end
      end
      S_LTGT: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_DIV;
        fpu_req.a = low_pct_q;
        fpu_req.b = DBL_HUNDRED;
        if (fpu_rsp.done) begin
          target_d = fpu_rsp.res;
          phase_d = 1'b0;
          state_d = S_WID;
        end
      end
      S_UV1: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_ADD;
        fpu_req.a = DBL_ONE;
        fpu_req.b = ratio_q;
        if (fpu_rsp.done) begin
          tmp_d = fpu_rsp.res;
          state_d = S_UV2;
        end
      end
      S_UV2: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_DIV;
        fpu_req.a = tmp_q;
        fpu_req.b = DBL_TWO;
        if (fpu_rsp.done) begin
          v_d = fpu_rsp.res;
          below_d = ratio_q;
          above_d = DBL_ONE;
          state_d = S_UTGT;
        end
      end
      S_UTGT: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_DIV;
        fpu_req.a = up_pct_q;
        fpu_req.b = DBL_HUNDRED;
        if (fpu_rsp.done) begin
          target_d = fpu_rsp.res;
          phase_d = 1'b1;
          state_d = S_WID;
        end
      end
      S_WID: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_SUB;
        fpu_req.a = above_q;
        fpu_req.b = below_q;
        if (fpu_rsp.done) begin
          tmp_d = fpu_rsp.res;
          state_d = S_CMPW;
        end
      end
      S_CMPW: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_GT;
        fpu_req.a = tmp_q;
        fpu_req.b = DBL_WIDTH;
        if (fpu_rsp.done) begin
          if (fpu_rsp.res[0]) begin
            state_d = S_ONEM;
          end else if (!phase_q) begin
            lo_d = v_q;
            if (x_q == n_q) begin
              up_d = DBL_ONE;
              state_d = S_OUT;
            end else begin
              state_d = S_UV1;
            end
          end else begin
            up_d = v_q;
            state_d = S_OUT;
          end
        end
      end
      S_ONEM: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_SUB;
        fpu_req.a = DBL_ONE;
        fpu_req.b = v_q;
        if (fpu_rsp.done) begin
          tmp_d = fpu_rsp.res;
          state_d = S_ODDS;
        end
      end
      S_ODDS: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_DIV;
        fpu_req.a = v_q;
        fpu_req.b = tmp_q;
        if (fpu_rsp.done) begin
          odds_d = fpu_rsp.res;
          term_d = DBL_ONE;
          part_d = DBL_ZERO;
          total_d = DBL_ZERO;
          k_d = '0;
          state_d = S_TTOT;
        end
      end
      S_TTOT: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_ADD;
        fpu_req.a = total_q;
        fpu_req.b = term_q;
        if (fpu_rsp.done) begin
          total_d = fpu_rsp.res;
          state_d = in_range ? S_TPART : S_TCHK;
        end
      end
      S_TPART: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_ADD;
        fpu_req.a = part_q;
        fpu_req.b = term_q;
        if (fpu_rsp.done) begin
          part_d = fpu_rsp.res;
          state_d = S_TCHK;
        end
      end
      S_TCHK: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_GT;
        fpu_req.a = total_q;
        fpu_req.b = DBL_RESCALE;
        if (fpu_rsp.done) begin
          state_d = fpu_rsp.res[0] ? S_RS1 : S_TINC;
        end
      end
      S_RS1: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_DIV;
        fpu_req.a = part_q;
        fpu_req.b = DBL_RESCALE;
        if (fpu_rsp.done) begin
          part_d = fpu_rsp.res;
          state_d = S_RS2;
        end
      end
      S_RS2: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_DIV;
        fpu_req.a = total_q;
        fpu_req.b = DBL_RESCALE;
        if (fpu_rsp.done) begin
          total_d = fpu_rsp.res;
          state_d = S_RS3;
        end
      end
      S_RS3: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_DIV;
        fpu_req.a = term_q;
        fpu_req.b = DBL_RESCALE;
        if (fpu_rsp.done) begin
          term_d = fpu_rsp.res;
          state_d = S_TINC;
        end
      end
      S_TINC: begin
        k_d = k_inc;
        state_d = (k_inc > n_ext) ? S_TFIN : S_TM1;
      end
      S_TM1: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_MUL;
        fpu_req.a = term_q;
        fpu_req.b = odds_q;
        if (fpu_rsp.done) begin
          term_d = fpu_rsp.res;
          state_d = S_TM2;
        end
      end
      S_TM2: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_MUL;
        fpu_req.a = term_q;
        fpu_req.b = int_to_dbl(n_ext + 11'd1 - k_q);
        if (fpu_rsp.done) begin
          term_d = fpu_rsp.res;
          state_d = S_TDIV;
        end
      end
      S_TDIV: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_DIV;
        fpu_req.a = term_q;
        fpu_req.b = int_to_dbl(k_q);
        if (fpu_rsp.done) begin
          term_d = fpu_rsp.res;
          state_d = S_TTOT;
        end
      end
      S_TFIN: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_DIV;
        fpu_req.a = part_q;
        fpu_req.b = total_q;
        if (fpu_rsp.done) begin
          tmp_d = fpu_rsp.res;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_GT;
        fpu_req.a = phase_q ? target_q : tmp_q;
        fpu_req.b = phase_q ? tmp_q : target_q;
        if (fpu_rsp.done) begin
          if (fpu_rsp.res[0]) begin
            above_d = v_q;
            dir_d = 1'b1;
          end else begin
            below_d = v_q;
            dir_d = 1'b0;
          end
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_ADD;
        fpu_req.a = dir_q ? below_q : v_q;
        fpu_req.b = dir_q ? v_q : above_q;
        if (fpu_rsp.done) begin
          tmp_d = fpu_rsp.res;
          state_d = S_HALF;
        end
      end
      S_HALF: begin
        fpu_req.start = !issued_q;
        fpu_req.op = FOP_DIV;
        fpu_req.a = tmp_q;
        fpu_req.b = DBL_TWO;
        if (fpu_rsp.done) begin
          v_d = fpu_rsp.res;
          state_d = S_WID;
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    issued_d = (issued_q | fpu_req.start) & ~fpu_rsp.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      issued_q  <= 1'b0;
      status_q  <= 1'b0;
      phase_q   <= 1'b0;
      dir_q     <= 1'b0;
      low_pct_q <= DBL_ONE;
      up_pct_q  <= DBL_ONE;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      status_q <= status_d;
      phase_q  <= phase_d;
      dir_q    <= dir_d;
      if (psel && penable && pwrite) begin
        if (paddr[3]) begin
          up_pct_q <= pwdata;
        end else begin
          low_pct_q <= pwdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    n_q      <= n_d;
    k_q      <= k_d;
    ratio_q  <= ratio_d;
    v_q      <= v_d;
    below_q  <= below_d;
    above_q  <= above_d;
    target_q <= target_d;
    odds_q   <= odds_d;
    term_q   <= term_d;
    part_q   <= part_d;
    total_q  <= total_d;
    tmp_q    <= tmp_d;
    lo_q     <= lo_d;
    up_q     <= up_d;
  end

  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("request taken while a result word is pending");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status) |->
      (out_o.lower_limit == DBL_ZERO && out_o.upper_limit == DBL_ZERO
       && out_o.ratio == DBL_ZERO))
    else $error("invalid result word carries nonzero limits");

  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpu_rsp.done |-> issued_q)
    else $error("FPU finished an operation that was never issued");

  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TTOT) |-> (k_q <= n_ext))
    else $error("term index ran past the trial count");

  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q != S_IDLE))
    else $error("accepted request did not start the sequencer");

endmodule
`default_nettype wire
